[rtl/mvna_pkg.sv]
// Package for the mesh vertex normal accumulator.
// Holds the sizes, the item function codes, the state types and the result struct.
// No dependencies.
`default_nettype none

package mvna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int COORD_BITS   = 16;

  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int IDX_W   = 10;
  localparam int FIELD_W = 16;
  localparam int CB      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int POS_W   = 3 * CB;
  localparam int DIFF_W  = CB + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SUM_W   = 48;
  localparam int SUMS_W  = 3 * SUM_W;

  // Normalization datapath.
  localparam int MAG_W  = 30;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SS_W   = SQ_W + 2;
  localparam int QFRAC  = 14;
  localparam int QONE   = 1 << QFRAC;
  localparam int Q_W    = QFRAC + 1;
  localparam int OUT_W  = Q_W + 1;
  localparam int QSHIFT = 2 * QFRAC + 2;
  localparam int ACC_W  = 96;
  localparam int J_W    = $clog2(Q_W);
  localparam int SH_W   = 6;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TRI  = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE,
    ST_TRI_A0, ST_TRI_A1, ST_TRI_A2, ST_TRI_D, ST_TRI_M, ST_TRI_W,
    ST_TRI_SR, ST_TRI_SW,
    ST_RD_A, ST_RD_S, ST_RD_N, ST_RD_OUT
  } top_state_t;

  typedef enum logic [3:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SUM, N_INIT, N_B0, N_B1, N_B2, N_B3, N_DONE
  } norm_state_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    zero;
  } norm_res_t;

endpackage

`default_nettype wire

[rtl/mvna_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/mvna_norm.sv]
// Iterative normalizer: turns one 3 x 48-bit sum into a rounded Q1.14 unit vector.
// Depends on mvna_pkg.
`default_nettype none

module mvna_norm import mvna_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUMS_W-1:0] sums,
  output logic              done,
  output norm_res_t         res
);

  norm_state_t nst, nst_next;

  logic [2:0]       neg;
  logic [SUM_W-1:0] mag [3];
  logic [SQ_W-1:0]  sq [3];
  logic [SS_W-1:0]  s;
  logic [1:0]       comp;
  logic [J_W-1:0]   bitpos;
  logic [Q_W-1:0]   q;
  logic [ACC_W-1:0] a_acc, b_acc, a_cand, b_cand, x_cmp, y_cmp, r_ref, s_ext;
  logic             mag_big, all_zero, hit;
  logic [Q_W-1:0]   q_fin;
  logic [OUT_W-1:0] q_out;
  logic [MAG_W-1:0] mcur;
  logic [SH_W-1:0]  sh_b, sh_a, sh_s;

  always_comb begin
    mag_big  = 1'b0;
    all_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (|mag[k][SUM_W-1:MAG_W]) begin
        mag_big = 1'b1;
      end
      if (|mag[k]) begin
        all_zero = 1'b0;
      end
    end
    s_ext = ACC_W'(s);
    mcur  = mag[comp][MAG_W-1:0];
    sh_b  = SH_W'(bitpos) + SH_W'(1);
    sh_a  = SH_W'(bitpos) + SH_W'(2);
    sh_s  = SH_W'({bitpos, 1'b0}) + SH_W'(2);
    hit   = (x_cmp <= y_cmp);
    q_fin = q | Q_W'(hit);
    q_out = neg[comp] ? -{1'b0, q_fin} : {1'b0, q_fin};
  end

  always_comb begin
    nst_next = nst;
    case (nst)
      N_IDLE:  if (start) nst_next = N_SHIFT;
      N_SHIFT: begin
        if (all_zero) begin
          nst_next = N_DONE;
        end else if (!mag_big) begin
          nst_next = N_SQ;
        end
      end
      N_SQ:    if (comp == 2'd2) nst_next = N_SUM;
      N_SUM:   nst_next = N_INIT;
      N_INIT:  nst_next = N_B0;
      N_B0:    nst_next = N_B1;
      N_B1:    nst_next = N_B2;
      N_B2:    nst_next = N_B3;
      N_B3: begin
        if (bitpos != '0) begin
          nst_next = N_B0;
        end else if (comp == 2'd2) begin
          nst_next = N_DONE;
        end else begin
          nst_next = N_INIT;
        end
      end
      N_DONE:  nst_next = N_IDLE;
      default: nst_next = N_IDLE;
    endcase
  end

  assign done = (nst == N_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      nst <= N_IDLE;
    end else begin
      nst <= nst_next;
    end
  end

  always_ff @(posedge clk) begin
    case (nst)
      N_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            neg[k] <= sums[k*SUM_W + SUM_W - 1];
            mag[k] <= sums[k*SUM_W + SUM_W - 1] ? -sums[k*SUM_W +: SUM_W]
                                                : sums[k*SUM_W +: SUM_W];
          end
          comp <= 2'd0;
        end
      end
      N_SHIFT: begin
        // One bit of shift per cycle until the largest magnitude fits in 30 bits.
        if (all_zero) begin
          res <= '{x: '0, y: '0, z: '0, zero: 1'b1};
        end else if (mag_big) begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= mag[k] >> 1;
          end
        end
      end
      N_SQ: begin
        sq[comp] <= SQ_W'(mcur) * SQ_W'(mcur);
        comp     <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
      end
      N_SUM: begin
        s        <= SS_W'(sq[0]) + SS_W'(sq[1]) + SS_W'(sq[2]);
        res.zero <= 1'b0;
      end
      N_INIT: begin
        r_ref  <= ACC_W'(sq[comp]) << QSHIFT;
        a_acc  <= '0;
        b_acc  <= '0;
        q      <= '0;
        bitpos <= J_W'(Q_W - 1);
      end
      // Bit-serial search for the largest q with (2q-1)^2 * s <= a^2 * 2^30.
      // a_acc holds (2q)^2 * s and b_acc holds 2q * s, so each trial is shifts and adds.
      N_B0: begin
        b_cand <= b_acc + (s_ext << sh_b);
        a_cand <= a_acc + (b_acc << sh_a);
      end
      N_B1: begin
        a_cand <= a_cand + (s_ext << sh_s);
      end
      N_B2: begin
        x_cmp <= a_cand + s_ext;
        y_cmp <= r_ref + (b_cand << 1);
      end
      N_B3: begin
        if (hit) begin
          a_acc     <= a_cand;
          b_acc     <= b_cand;
          q[bitpos] <= 1'b1;
        end
        bitpos <= bitpos - J_W'(1);
        if (bitpos == '0) begin
          case (comp)
            2'd0:    res.x <= q_out;
            2'd1:    res.y <= q_out;
            default: res.z <= q_out;
          endcase
          comp <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/mesh_vertex_normal_accumulator.sv]
// Top level of the mesh vertex normal accumulator.
// Depends on mvna_pkg, mvna_ram and mvna_norm.
`default_nettype none

// Positions and normal sums live in two RAMs indexed by vertex. After reset the block
// clears all MAX_VERTICES entries of the sum RAM, with in_stall high. A load item is
// handled in the idle state as it is taken. A triangle item runs through three position
// reads on the single read port, difference, product and cross stages, then a read and
// a write of the sum RAM for each of the three corners in turn. A read item of a nonzero
// sum waits for the normalizer: shifting by up to 18 bits, three squarings on one
// multiplier, then a bit-serial rounded division by the square root per component.
// A finished result sits in the output register, and new items are accepted meanwhile.
module mesh_vertex_normal_accumulator import mvna_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [IDX_W-1:0]          first_index,
  input  logic [IDX_W-1:0]          second_index,
  input  logic [IDX_W-1:0]          third_index,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic signed [FIELD_W-1:0] pos_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   norm_x,
  output logic signed [OUT_W-1:0]   norm_y,
  output logic signed [OUT_W-1:0]   norm_z,
  output logic                      zero_sum
);

  top_state_t state, state_next;

  logic [ADDR_W-1:0]        clr_addr;
  logic [IDX_W-1:0]         idx0, idx1, idx2, cidx;
  logic [1:0]               corner;
  logic signed [CB-1:0]     p0 [3];
  logic signed [CB-1:0]     p1 [3];
  logic signed [CB-1:0]     rd_coord [3];
  logic signed [DIFF_W-1:0] d0 [3];
  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [PROD_W-1:0] prod [6];
  logic signed [CROSS_W-1:0] w [3];

  logic              pos_we;
  logic [ADDR_W-1:0] pos_waddr, pos_raddr;
  logic [POS_W-1:0]  pos_wdata, pos_rdata;
  logic              sum_we;
  logic [ADDR_W-1:0] sum_waddr, sum_raddr;
  logic [SUMS_W-1:0] sum_wdata, sum_rdata;

  logic      norm_start, norm_done;
  norm_res_t norm_res, pend;
  logic      accept, out_free;

  function automatic logic idx_ok(logic [IDX_W-1:0] i);
    return 32'(i) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a,
                                               logic signed [CROSS_W-1:0] b);
    logic signed [SUM_W:0] t;
    t = $signed({a[SUM_W-1], a}) + (SUM_W+1)'(b);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  mvna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  mvna_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  mvna_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .sums  (sum_rdata),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_coord[k] = signed'(pos_rdata[k*CB +: CB]);
    end
    case (corner)
      2'd0:    cidx = idx0;
      2'd1:    cidx = idx1;
      default: cidx = idx2;
    endcase
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    pos_we     = 1'b0;
    pos_waddr  = ADDR_W'(first_index);
    pos_wdata  = {pos_z[CB-1:0], pos_y[CB-1:0], pos_x[CB-1:0]};
    pos_raddr  = ADDR_W'(idx0);
    sum_we     = 1'b0;
    sum_waddr  = clr_addr;
    sum_wdata  = '0;
    sum_raddr  = ADDR_W'(idx0);
    norm_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        sum_we = 1'b1;
        if (clr_addr == ADDR_W'(MAX_VERTICES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (func)
            FUNC_LOAD: begin
              if (idx_ok(first_index)) begin
                pos_we    = 1'b1;
                sum_we    = 1'b1;
                sum_waddr = ADDR_W'(first_index);
              end
            end
            FUNC_TRI: begin
              if (idx_ok(first_index) && idx_ok(second_index) && idx_ok(third_index)) begin
                state_next = ST_TRI_A0;
              end
            end
            FUNC_READ: state_next = idx_ok(first_index) ? ST_RD_A : ST_RD_OUT;
            default: ;
          endcase
        end
      end
      ST_TRI_A0: state_next = ST_TRI_A1;
      ST_TRI_A1: begin
        pos_raddr  = ADDR_W'(idx1);
        state_next = ST_TRI_A2;
      end
      ST_TRI_A2: begin
        pos_raddr  = ADDR_W'(idx2);
        state_next = ST_TRI_D;
      end
      ST_TRI_D:  state_next = ST_TRI_M;
      ST_TRI_M:  state_next = ST_TRI_W;
      ST_TRI_W:  state_next = ST_TRI_SR;
      ST_TRI_SR: begin
        sum_raddr  = ADDR_W'(cidx);
        state_next = ST_TRI_SW;
      end
      ST_TRI_SW: begin
        // The next corner reads in the cycle after this write, so a repeated corner sees it.
        sum_we     = 1'b1;
        sum_waddr  = ADDR_W'(cidx);
        sum_wdata  = {sat_add(sum_rdata[2*SUM_W +: SUM_W], w[2]),
                      sat_add(sum_rdata[SUM_W +: SUM_W], w[1]),
                      sat_add(sum_rdata[0 +: SUM_W], w[0])};
        state_next = (corner == 2'd2) ? ST_IDLE : ST_TRI_SR;
      end
      ST_RD_A:   state_next = ST_RD_S;
      ST_RD_S: begin
        norm_start = 1'b1;
        state_next = ST_RD_N;
      end
      ST_RD_N:   if (norm_done) state_next = ST_RD_OUT;
      ST_RD_OUT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_RD_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx0   <= first_index;
          idx1   <= second_index;
          idx2   <= third_index;
          corner <= 2'd0;
          pend   <= '{x: '0, y: '0, z: '0, zero: 1'b1};
        end
      end
      ST_TRI_A1: p0 <= rd_coord;
      ST_TRI_A2: p1 <= rd_coord;
      ST_TRI_D: begin
        for (int k = 0; k < 3; k++) begin
          d0[k] <= DIFF_W'(p1[k]) - DIFF_W'(p0[k]);
          d1[k] <= DIFF_W'(rd_coord[k]) - DIFF_W'(p0[k]);
        end
      end
      ST_TRI_M: begin
        prod[0] <= PROD_W'(d1[1]) * PROD_W'(d0[2]);
        prod[1] <= PROD_W'(d1[2]) * PROD_W'(d0[1]);
        prod[2] <= PROD_W'(d1[2]) * PROD_W'(d0[0]);
        prod[3] <= PROD_W'(d1[0]) * PROD_W'(d0[2]);
        prod[4] <= PROD_W'(d1[0]) * PROD_W'(d0[1]);
        prod[5] <= PROD_W'(d1[1]) * PROD_W'(d0[0]);
      end
      ST_TRI_W: begin
        w[0] <= CROSS_W'(prod[0]) - CROSS_W'(prod[1]);
        w[1] <= CROSS_W'(prod[2]) - CROSS_W'(prod[3]);
        w[2] <= CROSS_W'(prod[4]) - CROSS_W'(prod[5]);
      end
      ST_TRI_SW: corner <= corner + 2'd1;
      ST_RD_N:   if (norm_done) pend <= norm_res;
      ST_RD_OUT: begin
        if (out_free) begin
          norm_x   <= pend.x;
          norm_y   <= pend.y;
          norm_z   <= pend.z;
          zero_sum <= pend.zero;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/mvna_checker.sv]
// Port-level checks for the mesh vertex normal accumulator, bound to the top level.
// Depends on mvna_pkg and mesh_vertex_normal_accumulator.
`default_nettype none

module mvna_props import mvna_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [1:0]              func,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [OUT_W-1:0] norm_x,
  input logic signed [OUT_W-1:0] norm_y,
  input logic signed [OUT_W-1:0] norm_z,
  input logic                    zero_sum
);

  // The sum RAM is being cleared right after reset, so no item may enter.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("item channel open right after reset");

  // A read item keeps the block busy while the normal is computed.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_READ |=> in_stall)
    else $error("block took a new item right after a read item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(norm_x) && $stable(zero_sum))
    else $error("stalled result changed or dropped");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_sum |-> norm_x == 0 && norm_y == 0 && norm_z == 0)
    else $error("zero-sum result carries nonzero components");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> int'(norm_x) <= QONE && int'(norm_x) >= -QONE &&
                  int'(norm_y) <= QONE && int'(norm_y) >= -QONE &&
                  int'(norm_z) <= QONE && int'(norm_z) >= -QONE)
    else $error("normal component outside the unit range");

endmodule

bind mesh_vertex_normal_accumulator mvna_props u_mvna_props (.*);

`default_nettype wire

[dv/mvna_checker.sv]
// Checker for the mesh vertex normal accumulator: watches both channels, predicts results.
// Depends on mvna_pkg for the sizes, the function codes and the result struct.
`timescale 1ns / 100ps

module mvna_checker import mvna_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [IDX_W-1:0]          first_index,
  input  logic [IDX_W-1:0]          second_index,
  input  logic [IDX_W-1:0]          third_index,
  input  logic signed [FIELD_W-1:0] pos_x,
  input  logic signed [FIELD_W-1:0] pos_y,
  input  logic signed [FIELD_W-1:0] pos_z,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [OUT_W-1:0]   norm_x,
  input  logic signed [OUT_W-1:0]   norm_y,
  input  logic signed [OUT_W-1:0]   norm_z,
  input  logic                      zero_sum,
  output int                        fail_count,
  output int                        pending
);

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic signed [FIELD_W-1:0] vert_pos [MAX_VERTICES][3];
  longint                    normal_sum [MAX_VERTICES][3];
  norm_res_t                 normals_due [$];

  assign pending = normals_due.size();

  function automatic longint add_sat(longint a, longint b);
    longint v;
    v = a + b;
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  // Largest q with (2q-1)^2 * s <= a^2 * 2^30, i.e. rounded 16384*a/sqrt(s).
  function automatic longint unsigned unit_component(longint unsigned a, longint unsigned s);
    bit [127:0] rhs, prod;
    longint unsigned lo, hi, q, t;
    rhs = 128'(a * a) << 30;
    lo = 0;
    hi = QONE;
    while (lo < hi) begin
      q = (lo + hi + 1) >> 1;
      t = 2 * q - 1;
      prod = 128'(t * t) * 128'(s);
      if (prod <= rhs) lo = q;
      else hi = q - 1;
    end
    return lo;
  endfunction

  function automatic norm_res_t normalize(longint sv[3]);
    longint unsigned m[3];
    longint unsigned mx, s, q;
    int sh;
    norm_res_t r;
    logic [OUT_W-1:0] c[3];
    r = '0;
    for (int k = 0; k < 3; k++) m[k] = (sv[k] < 0) ? -sv[k] : sv[k];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      r.zero = 1'b1;
      return r;
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 30)) sh++;
    for (int k = 0; k < 3; k++) m[k] = m[k] >> sh;
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    for (int k = 0; k < 3; k++) begin
      q = unit_component(m[k], s);
      if (sv[k] < 0) q = -q;
      c[k] = q[OUT_W-1:0];
    end
    r.x = c[0];
    r.y = c[1];
    r.z = c[2];
    return r;
  endfunction

  task automatic add_triangle(int v0, int v1, int v2);
    longint d0[3], d1[3], w[3];
    int corner[3];
    for (int k = 0; k < 3; k++) begin
      d0[k] = longint'(vert_pos[v1][k]) - longint'(vert_pos[v0][k]);
      d1[k] = longint'(vert_pos[v2][k]) - longint'(vert_pos[v0][k]);
    end
    w[0] = d1[1] * d0[2] - d1[2] * d0[1];
    w[1] = d1[2] * d0[0] - d1[0] * d0[2];
    w[2] = d1[0] * d0[1] - d1[1] * d0[0];
    corner = '{v0, v1, v2};
    // A repeated corner gets the weight once per listing.
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++)
        normal_sum[corner[c]][k] = add_sat(normal_sum[corner[c]][k], w[k]);
  endtask

  always @(posedge clk) begin
    norm_res_t exp_n, got;
    longint sv[3];
    if (rst) begin
      foreach (normal_sum[i]) normal_sum[i] = '{0, 0, 0};
      normals_due.delete();
      fail_count = 0;
    end else begin
      // Results leave before any item of this edge can have produced one.
      if (out_valid && !out_stall) begin
        got = '{x: norm_x, y: norm_y, z: norm_z, zero: zero_sum};
        if (normals_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result x=%0d y=%0d z=%0d zero=%0b",
                     $realtime, norm_x, norm_y, norm_z, zero_sum);
        end else begin
          exp_n = normals_due.pop_front();
          if (got.x !== exp_n.x || got.y !== exp_n.y || got.z !== exp_n.z ||
              got.zero !== exp_n.zero) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp x=%0d y=%0d z=%0d zero=%0b",
                        " got x=%0d y=%0d z=%0d zero=%0b"},
                       $realtime, exp_n.x, exp_n.y, exp_n.z, exp_n.zero,
                       got.x, got.y, got.z, got.zero);
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (func)
          FUNC_LOAD: begin
            vert_pos[first_index] = '{pos_x, pos_y, pos_z};
            normal_sum[first_index] = '{0, 0, 0};
          end
          FUNC_TRI: add_triangle(first_index, second_index, third_index);
          FUNC_READ: begin
            sv = normal_sum[first_index];
            normals_due = {normals_due, normalize(sv)};
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the mesh vertex normal accumulator: stimulus, back pressure and verdict.
// Depends on mvna_pkg, the block itself and mvna_checker.
`timescale 1ns / 100ps

module tb import mvna_pkg::*; ;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 400;
  localparam int WIDE_TRIANGLES = 200;
  localparam int RANDOM_ITEMS   = 1020;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_LOAD;
  logic [IDX_W-1:0] first_index = '0, second_index = '0, third_index = '0;
  logic signed [FIELD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] norm_x, norm_y, norm_z;
  logic zero_sum;
  int fail_count, pending;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  bit loaded [MAX_VERTICES];
  int loaded_list [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mesh_vertex_normal_accumulator DUT (
    .clk, .rst, .in_valid, .in_stall, .func, .first_index, .second_index,
    .third_index, .pos_x, .pos_y, .pos_z, .out_valid, .out_stall,
    .norm_x, .norm_y, .norm_z, .zero_sum
  );

  mvna_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .func, .first_index, .second_index,
    .third_index, .pos_x, .pos_y, .pos_z, .out_valid, .out_stall,
    .norm_x, .norm_y, .norm_z, .zero_sum, .fail_count, .pending
  );

  // Receiver: random stalls, one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] f, int a, int b, int c,
                           logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    first_index <= IDX_W'(a);
    second_index <= IDX_W'(b);
    third_index <= IDX_W'(c);
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f == FUNC_LOAD && !loaded[a]) begin
      loaded[a] = 1'b1;
      loaded_list = {loaded_list, a};
    end
  endtask

  task automatic load_vertex(int v, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_item(FUNC_LOAD, v, $urandom, $urandom, x, y, z);
  endtask

  task automatic read_vertex(int v);
    send_item(FUNC_READ, v, $urandom, $urandom,
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1: return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int rand_index();
    return ($urandom_range(99) < 80) ? $urandom_range(31) : $urandom_range(MAX_VERTICES - 1);
  endfunction

  function automatic int rand_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  initial begin
    int a, b, c, pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items: extreme coordinates, zero sums, repeated corners, unused code.
    load_vertex(0, 16'h7FFF, 16'h8000, 16'h0000);
    load_vertex(1, 16'h8000, 16'h7FFF, 16'hFFFF);
    load_vertex(2, 16'h0000, 16'h0000, 16'h7FFF);
    load_vertex(1023, 16'hFFFF, 16'hFFFF, 16'h8000);
    read_vertex(0);
    read_vertex(500);
    send_item(FUNC_TRI, 0, 1, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    read_vertex(0);
    read_vertex(1);
    read_vertex(2);
    send_item(FUNC_TRI, 1023, 0, 1, 16'h0, 16'h0, 16'h0);
    send_item(FUNC_TRI, 2, 2, 1023, 16'h0, 16'h0, 16'h0);
    send_item(FUNC_TRI, 0, 0, 0, 16'h0, 16'h0, 16'h0);
    read_vertex(1023);
    read_vertex(2);
    send_item(FUNC_UNUSED, 1023, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_vertex(0, 16'h0001, 16'h0002, 16'h0003);
    read_vertex(0);
    read_vertex(1);

    // The same wide triangle grows the x and z sums far past 30 bits, so reads must shift.
    load_vertex(1000, 16'h8000, 16'h8000, 16'h8000);
    load_vertex(1001, 16'h8000, 16'h7FFF, 16'h8000);
    load_vertex(1002, 16'h7FFF, 16'h8000, 16'h7FFF);
    for (int i = 0; i < WIDE_TRIANGLES; i++) begin
      send_item(FUNC_TRI, 1000, 1001, 1002,
                16'($urandom), 16'($urandom), 16'($urandom));
      if (i % 64 == 63) read_vertex(1000 + $urandom_range(2));
    end
    read_vertex(1000);
    read_vertex(1001);
    read_vertex(1002);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_req <= 1'b1;
      if (i == 500) quiet <= 1'b1;
      if (i == 700) quiet <= 1'b0;
      pick = $urandom_range(99);
      if (pick < 28 || loaded_list.size() < 3) begin
        load_vertex(rand_index(), rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 68) begin
        a = rand_loaded();
        b = rand_loaded();
        c = ($urandom_range(9) == 0) ? a : rand_loaded();
        send_item(FUNC_TRI, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 95) begin
        read_vertex(($urandom_range(99) < 60) ? rand_loaded() : rand_index());
      end else begin
        send_item(FUNC_UNUSED, $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
